// ===== design/mconv_pkg.sv =====
package mconv_pkg;

    // operation codes of an input transaction
    localparam logic [1:0] OP_WEIGHT   = 2'd0;
    localparam logic [1:0] OP_BIAS     = 2'd1;
    localparam logic [1:0] OP_SAMPLE   = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_INPUT_CHANNELS  = 3'd0;
    localparam logic [2:0] REG_OUTPUT_CHANNELS = 3'd1;
    localparam logic [2:0] REG_KERNEL_TAPS     = 3'd2;
    localparam logic [2:0] REG_DILATION        = 3'd3;
    localparam logic [2:0] REG_STRIDE          = 3'd4;
    localparam logic [2:0] REG_BIAS_ENABLE     = 3'd5;

    // accumulator width: 256 products of 31 bits plus a 32-bit bias fit easily
    localparam int ACC_W   = 48;
    // weight address carried along the cell row (covers 64 x 64 entries)
    localparam int WADDR_W = 12;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [3:0]          output_channel;
        logic [3:0]          input_channel;
        logic [3:0]          tap_index;
        logic signed [15:0]  coeff_or_sample;
        logic signed [31:0]  bias_value;
    } in_item_t;

    typedef struct packed {
        logic [3:0]          out_channel;
        logic [15:0]         position;
        logic signed [31:0]  result;
        logic                last;
    } out_item_t;

    // one multiply-accumulate token handed from cell to cell
    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last;
        logic signed [15:0]  sample;
        logic [WADDR_W-1:0]  waddr;
    } tok_t;

    // control of the result shift chain
    typedef struct packed {
        logic load;
        logic shift;
    } chain_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        begin
            hi = {{(ACC_W-31){1'b0}}, 31'h7fffffff};
            lo = {{(ACC_W-31){1'b1}}, 31'h00000000};
            if (a > hi)
                sat32 = 32'sh7fffffff;
            else if (a < lo)
                sat32 = 32'sh80000000;
            else
                sat32 = a[31:0];
        end
    endfunction

endpackage

// ===== design/mconv_cell.sv =====
module mconv_cell
    import mconv_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int WAW   = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  tok_t                tok_in,
    output tok_t                tok_out,
    input  logic                wr_en,
    input  logic [WAW-1:0]      wr_addr,
    input  logic signed [15:0]  wr_data,
    input  logic                bias_wr,
    input  logic signed [31:0]  bias_wdata,
    input  logic                bias_enable,
    input  chain_ctl_t          ctl,
    input  logic signed [31:0]  res_in,
    output logic signed [31:0]  res_out,
    output logic                done
);

    logic signed [15:0]       wmem [DEPTH];
    logic signed [15:0]       w_q;
    tok_t                     s1_reg;
    logic signed [31:0]       prod_reg;
    logic                     p_valid_reg;
    logic                     p_first_reg;
    logic                     p_last_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  base;
    logic signed [31:0]       bias_reg;
    logic                     done_reg;
    logic signed [31:0]       res_reg;

    // weight memory of this output channel
    always_ff @(posedge clk)
    begin
        if (wr_en)
            wmem[wr_addr] <= wr_data;
        w_q <= wmem[tok_in.waddr[WAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (bias_wr)
            bias_reg <= bias_wdata;
    end

    // token stage, also the hand-off to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg      <= '0;
            p_valid_reg <= 1'b0;
            p_first_reg <= 1'b0;
            p_last_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            s1_reg      <= tok_in;
            p_valid_reg <= s1_reg.valid;
            p_first_reg <= s1_reg.first;
            p_last_reg  <= s1_reg.last;
            done_reg    <= p_valid_reg && p_last_reg;
        end
    end

    assign tok_out = s1_reg;

    // product stage
    always_ff @(posedge clk)
    begin
        prod_reg <= 32'(s1_reg.sample * w_q);
    end

    // accumulate stage
    always_comb
    begin
        if (p_first_reg)
            base = bias_enable ? ACC_W'(bias_reg) : '0;
        else
            base = acc_reg;
        acc_next = base + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (p_valid_reg)
            acc_reg <= acc_next;
    end

    // result shift chain toward cell zero
    always_ff @(posedge clk)
    begin
        if (ctl.load)
            res_reg <= sat32(acc_reg);
        else if (ctl.shift)
            res_reg <= res_in;
    end

    assign res_out = res_reg;
    assign done    = done_reg;

endmodule

// ===== design/multichannel_conv1d.sv =====
// Multi-channel dilated, strided 1D convolution.
// Input channel (in_valid / in_stall / in_data) carries three kinds of transaction:
// weight writes, bias writes and samples. Samples arrive column by column with
// input channels in order; a sample on the last configured channel closes a column.
// Output channel (out_valid / out_stall / out_data) carries one result per output
// channel of a position, last set on the final channel.
// Configuration is written through cfg_write / cfg_index / cfg_data; the user must
// do so only while idle, which the block does not enforce. Weight, bias and
// non-closing sample transactions leave the block idle. A column that yields a
// position holds the input while the MAC tokens run down the row of cells (one
// cell per output channel), then while results shift out of the cell row, one per
// cycle unless the receiver stalls.
// After reset all HISTORY_COLUMNS * MAX_INPUTS entries of the history memory are
// cleared, one entry per cycle; in_stall stays high during that pass.
// When the receiver stalls, the result register holds and the row waits; once the
// last result of a position sits in the output register, new transactions are taken.
module multichannel_conv1d
    import mconv_pkg::*;
#(
    parameter int MAX_INPUTS      = 16,
    parameter int MAX_OUTPUTS     = 16,
    parameter int MAX_TAPS        = 16,
    parameter int HISTORY_COLUMNS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data,
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [4:0] cfg_data
);

    localparam int NI_MAX = (MAX_INPUTS < 16) ? MAX_INPUTS : 16;
    localparam int NO_MAX = (MAX_OUTPUTS < 16) ? MAX_OUTPUTS : 16;
    localparam int NT_MAX = (MAX_TAPS < 16) ? MAX_TAPS : 16;
    localparam int WDEPTH = MAX_INPUTS * MAX_TAPS;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int HDEPTH = HISTORY_COLUMNS * MAX_INPUTS;
    localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int SW     = (HISTORY_COLUMNS > 1) ? $clog2(HISTORY_COLUMNS) : 1;
    localparam int CAP1   = HISTORY_COLUMNS;
    localparam int CAP2   = (HISTORY_COLUMNS - 1) / 2 + 1;
    localparam int CAP3   = (HISTORY_COLUMNS - 1) / 3 + 1;
    localparam int CAP4   = (HISTORY_COLUMNS - 1) / 4 + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    // configuration registers
    logic [4:0] in_ch_reg, out_ch_reg, taps_reg, stride_reg;
    logic [2:0] dil_reg;
    logic       bias_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch_reg   <= 5'd1;
            out_ch_reg  <= 5'd1;
            taps_reg    <= 5'd1;
            dil_reg     <= 3'd1;
            stride_reg  <= 5'd1;
            bias_en_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_INPUT_CHANNELS:  in_ch_reg   <= cfg_data;
                REG_OUTPUT_CHANNELS: out_ch_reg  <= cfg_data;
                REG_KERNEL_TAPS:     taps_reg    <= cfg_data;
                REG_DILATION:        dil_reg     <= cfg_data[2:0];
                REG_STRIDE:          stride_reg  <= cfg_data;
                REG_BIAS_ENABLE:     bias_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective configuration
    logic [4:0] n_in, n_out, taps_lim, taps, str;
    logic [2:0] dil;
    logic [8:0] cap;
    logic [8:0] extent;

    always_comb
    begin
        n_in     = (in_ch_reg == 5'd0) ? 5'd1 :
                   ((32'(in_ch_reg) > NI_MAX) ? 5'(NI_MAX) : in_ch_reg);
        n_out    = (out_ch_reg == 5'd0) ? 5'd1 :
                   ((32'(out_ch_reg) > NO_MAX) ? 5'(NO_MAX) : out_ch_reg);
        taps_lim = (taps_reg == 5'd0) ? 5'd1 :
                   ((32'(taps_reg) > NT_MAX) ? 5'(NT_MAX) : taps_reg);
        dil      = (dil_reg == 3'd0) ? 3'd1 : ((dil_reg > 3'd4) ? 3'd4 : dil_reg);
        str      = (stride_reg == 5'd0) ? 5'd1 :
                   ((stride_reg > 5'd16) ? 5'd16 : stride_reg);
        case (dil)
            3'd1:    cap = 9'(CAP1);
            3'd2:    cap = 9'(CAP2);
            3'd3:    cap = 9'(CAP3);
            default: cap = 9'(CAP4);
        endcase
        taps   = ({4'd0, taps_lim} > cap) ? cap[4:0] : taps_lim;
        extent = 9'(9'(dil) * 9'(taps - 5'd1)) + 9'd1;
    end

    // input decode
    logic [2:0] state_reg;
    logic       in_acc, is_wt, is_bias, is_smp, col_done;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        is_wt    = (in_data.opcode == OP_WEIGHT) &&
                   (32'(in_data.output_channel) < MAX_OUTPUTS) &&
                   (32'(in_data.input_channel) < MAX_INPUTS) &&
                   (32'(in_data.tap_index) < MAX_TAPS);
        is_bias  = (in_data.opcode == OP_BIAS) &&
                   (32'(in_data.output_channel) < MAX_OUTPUTS);
        is_smp   = (in_data.opcode == OP_SAMPLE) && ({1'b0, in_data.input_channel} < n_in);
        col_done = is_smp && ({1'b0, in_data.input_channel} == n_in - 5'd1);
    end

    // column bookkeeping and sequencer
    logic [15:0]   seen_reg, seen_next, pos_reg;
    logic [3:0]    phase_reg;
    logic [SW-1:0] wslot_reg, base_reg, age_reg, rslot;
    logic [3:0]    c_reg, k_reg, o_reg;
    logic [HAW-1:0] clr_reg;
    logic          last_item;
    logic          rd_v_reg, rd_first_reg, rd_last_reg;
    logic [WADDR_W-1:0] rd_waddr_reg;
    logic          take;
    chain_ctl_t    ctl;
    logic [MAX_OUTPUTS-1:0] cell_done;
    logic signed [31:0] res_w [MAX_OUTPUTS+1];
    out_item_t     out_reg;
    logic          out_valid_reg;

    assign seen_next = (seen_reg == 16'hFFFF) ? seen_reg : seen_reg + 16'd1;
    assign last_item = ({1'b0, c_reg} == n_in - 5'd1) && ({1'b0, k_reg} == taps - 5'd1);
    assign take      = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (base_reg >= age_reg)
            rslot = base_reg - age_reg;
        else
            rslot = SW'({1'b0, base_reg} + (SW+1)'(HISTORY_COLUMNS) - {1'b0, age_reg});
    end

    always_comb
    begin
        ctl.load  = (state_reg == S_DRAIN) && cell_done[MAX_OUTPUTS-1];
        ctl.shift = (state_reg == S_OUT) && take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            seen_reg      <= '0;
            phase_reg     <= '0;
            pos_reg       <= '0;
            wslot_reg     <= '0;
            base_reg      <= '0;
            age_reg       <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            o_reg         <= '0;
            rd_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg      <= (state_reg == S_RUN);
            out_valid_reg <= ((state_reg == S_OUT) && take) || (out_valid_reg && out_stall);
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + HAW'(1);
                    if (32'(clr_reg) == HDEPTH - 1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_acc && col_done)
                    begin
                        seen_reg  <= seen_next;
                        base_reg  <= wslot_reg;
                        wslot_reg <= (32'(wslot_reg) == HISTORY_COLUMNS - 1) ?
                                     '0 : wslot_reg + SW'(1);
                        if (seen_next >= 16'(extent))
                        begin
                            phase_reg <= (5'(phase_reg) + 5'd1 >= str) ?
                                         4'd0 : phase_reg + 4'd1;
                            if (phase_reg == 4'd0)
                            begin
                                state_reg <= S_RUN;
                                c_reg     <= '0;
                                k_reg     <= '0;
                                age_reg   <= SW'(extent - 9'd1);
                            end
                        end
                    end
                end
                S_RUN:
                begin
                    if ({1'b0, k_reg} == taps - 5'd1)
                    begin
                        k_reg   <= '0;
                        c_reg   <= c_reg + 4'd1;
                        age_reg <= SW'(extent - 9'd1);
                    end
                    else
                    begin
                        k_reg   <= k_reg + 4'd1;
                        age_reg <= age_reg - SW'(dil);
                    end
                    if (last_item)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    if (cell_done[MAX_OUTPUTS-1])
                    begin
                        state_reg <= S_OUT;
                        o_reg     <= '0;
                    end
                end
                S_OUT:
                begin
                    if (take)
                    begin
                        o_reg <= o_reg + 4'd1;
                        if ({1'b0, o_reg} == n_out - 5'd1)
                        begin
                            state_reg <= S_IDLE;
                            pos_reg   <= pos_reg + 16'd1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // read token flags, aligned with the registered history read
    always_ff @(posedge clk)
    begin
        rd_first_reg <= (c_reg == 4'd0) && (k_reg == 4'd0);
        rd_last_reg  <= last_item;
        rd_waddr_reg <= WADDR_W'(32'(c_reg) * MAX_TAPS + 32'(k_reg));
    end

    // result output register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && take)
        begin
            out_reg.out_channel <= o_reg;
            out_reg.position    <= pos_reg;
            out_reg.result      <= res_w[0];
            out_reg.last        <= ({1'b0, o_reg} == n_out - 5'd1);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // column history memory
    logic signed [15:0] hmem [HDEPTH];
    logic signed [15:0] hist_q;
    logic               hwe;
    logic [HAW-1:0]     hwa, hra;
    logic signed [15:0] hwd;

    always_comb
    begin
        hwe = (state_reg == S_CLEAR) || (in_acc && is_smp);
        hwa = (state_reg == S_CLEAR) ? clr_reg :
              HAW'(32'(wslot_reg) * MAX_INPUTS + 32'(in_data.input_channel));
        hwd = (state_reg == S_CLEAR) ? 16'sd0 : in_data.coeff_or_sample;
        hra = HAW'(32'(rslot) * MAX_INPUTS + 32'(c_reg));
    end

    always_ff @(posedge clk)
    begin
        if (hwe)
            hmem[hwa] <= hwd;
        hist_q <= hmem[hra];
    end

    // row of MAC cells, one per output channel
    tok_t tok_w [MAX_OUTPUTS+1];

    always_comb
    begin
        tok_w[0].valid  = rd_v_reg;
        tok_w[0].first  = rd_first_reg;
        tok_w[0].last   = rd_last_reg;
        tok_w[0].sample = hist_q;
        tok_w[0].waddr  = rd_waddr_reg;
    end

    assign res_w[MAX_OUTPUTS] = 32'sd0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_OUTPUTS; gi++)
        begin : g_cell
            mconv_cell #(
                .DEPTH (WDEPTH),
                .WAW   (WAW)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .tok_in      (tok_w[gi]),
                .tok_out     (tok_w[gi+1]),
                .wr_en       (in_acc && is_wt && (32'(in_data.output_channel) == gi)),
                .wr_addr     (WAW'(32'(in_data.input_channel) * MAX_TAPS +
                                   32'(in_data.tap_index))),
                .wr_data     (in_data.coeff_or_sample),
                .bias_wr     (in_acc && is_bias && (32'(in_data.output_channel) == gi)),
                .bias_wdata  (in_data.bias_value),
                .bias_enable (bias_en_reg),
                .ctl         (ctl),
                .res_in      (res_w[gi+1]),
                .res_out     (res_w[gi]),
                .done        (cell_done[gi])
            );
        end
    endgenerate

endmodule

// ===== design/mconv_check.sv =====
module mconv_check
    import mconv_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // history clearing pass holds the input right after reset
    a_clear_after_reset: assert property (@(posedge clk)
        $past(!rst_n) |-> in_stall)
        else $error("input taken during history clear");

    // a stalled result transaction stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");

    // input held while a position is still being delivered
    a_busy_mid_position: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> in_stall)
        else $error("input taken in the middle of a position");

    // channels of a position come in order
    a_channel_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last ##1 out_valid |->
            out_data.out_channel == $past(out_data.out_channel) + 4'd1)
        else $error("output channel out of order");

endmodule

bind multichannel_conv1d mconv_check u_mconv_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== verif/tb_multichannel_conv1d.sv =====
`timescale 1ns / 100ps

module tb_multichannel_conv1d
    import mconv_pkg::*;
();

    localparam int HIST_COLS   = 64;
    localparam int SETTLE      = 400;
    localparam int CYCLE_LIMIT = 1000000;

    // clock, reset and block ports
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       cfg_write = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [4:0] cfg_data = '0;

    multichannel_conv1d uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // predictor state
    logic signed [15:0] coeffs [16][16][16];
    logic signed [31:0] biases [16];
    logic signed [15:0] history [HIST_COLS][16];
    int                 cols_done;
    int                 phase;
    int                 pos_count;
    int                 ring_slot;
    logic [4:0]         raw_regs [6];
    int                 n_in, n_out, n_taps, dil, str, span;
    out_item_t          conv_results_due [$];

    int  mismatches = 0;
    int  cycles = 0;
    bit  in_gaps = 1'b1;
    bit  out_gaps = 1'b1;
    int  stall_left = 0;

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // effective geometry after saturation of the raw register values
    task automatic refresh_geometry();
        n_in   = clip(int'(raw_regs[REG_INPUT_CHANNELS]), 1, 16);
        n_out  = clip(int'(raw_regs[REG_OUTPUT_CHANNELS]), 1, 16);
        dil    = clip(int'(raw_regs[REG_DILATION]), 1, 4);
        str    = clip(int'(raw_regs[REG_STRIDE]), 1, 16);
        n_taps = clip(int'(raw_regs[REG_KERNEL_TAPS]), 1, 16);
        if (n_taps > (HIST_COLS - 1) / dil + 1)
            n_taps = (HIST_COLS - 1) / dil + 1;
        span = dil * (n_taps - 1) + 1;
    endtask

    // convolution predictor: updates stores and history, queues expected results
    task automatic conv_model_step(input in_item_t it);
        longint    acc;
        int        age;
        int        slot;
        out_item_t r;
        case (it.opcode)
            OP_WEIGHT: coeffs[it.output_channel][it.input_channel][it.tap_index] =
                it.coeff_or_sample;
            OP_BIAS: biases[it.output_channel] = it.bias_value;
            OP_SAMPLE:
            begin
                if (it.input_channel < n_in)
                begin
                    history[ring_slot][it.input_channel] = it.coeff_or_sample;
                    if (it.input_channel == n_in - 1)
                    begin
                        if (cols_done < 65535)
                            cols_done++;
                        if (cols_done >= span)
                        begin
                            if (phase == 0)
                            begin
                                for (int o = 0; o < n_out; o++)
                                begin
                                    acc = raw_regs[REG_BIAS_ENABLE][0] ? longint'(biases[o]) : 0;
                                    for (int c = 0; c < n_in; c++)
                                        for (int k = 0; k < n_taps; k++)
                                        begin
                                            age  = (span - 1) - k * dil;
                                            slot = (ring_slot + HIST_COLS - age) % HIST_COLS;
                                            acc += longint'(history[slot][c]) *
                                                   longint'(coeffs[o][c][k]);
                                        end
                                    if (acc > 64'sd2147483647)
                                        acc = 64'sd2147483647;
                                    if (acc < -64'sd2147483648)
                                        acc = -64'sd2147483648;
                                    r.out_channel = o[3:0];
                                    r.position    = pos_count[15:0];
                                    r.result      = acc[31:0];
                                    r.last        = (o == n_out - 1);
                                    conv_results_due.push_back(r);
                                end
                                pos_count = (pos_count + 1) & 16'hffff;
                            end
                            phase = (phase + 1 >= str) ? 0 : phase + 1;
                        end
                        ring_slot = (ring_slot + 1) % HIST_COLS;
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // one input transaction: optional gap, then hold until accepted
    task automatic send_item(input in_item_t it);
        int g;
        g = in_gaps ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        conv_model_step(it);
    endtask

    function automatic in_item_t make_item(input logic [1:0] op, input int oc, input int ic,
                                           input int tap, input logic [15:0] val,
                                           input logic [31:0] bv);
        in_item_t it;
        it.opcode          = op;
        it.output_channel  = oc[3:0];
        it.input_channel   = ic[3:0];
        it.tap_index       = tap[3:0];
        it.coeff_or_sample = val;
        it.bias_value      = bv;
        return it;
    endfunction

    function automatic logic [15:0] rand_value();
        logic [15:0] v;
        v = 16'($urandom_range(0, 65535));
        return ($urandom_range(0, 1) == 1) ? v : {{6{v[15]}}, v[15:6]};
    endfunction

    // wait until every expected result is out, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (conv_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [4:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        raw_regs[idx] = v;
        refresh_geometry();
        @(posedge clk);
    endtask

    task automatic configure(input int ic, input int oc, input int tp, input int dl,
                             input int st, input int be);
        drain();
        write_reg(REG_INPUT_CHANNELS, ic[4:0]);
        write_reg(REG_OUTPUT_CHANNELS, oc[4:0]);
        write_reg(REG_KERNEL_TAPS, tp[4:0]);
        write_reg(REG_DILATION, dl[4:0]);
        write_reg(REG_STRIDE, st[4:0]);
        write_reg(REG_BIAS_ENABLE, be[4:0]);
    endtask

    // fill every weight and bias the current geometry reads
    task automatic load_coeffs(input bit extremes);
        logic [15:0] w;
        for (int o = 0; o < n_out; o++)
            for (int c = 0; c < n_in; c++)
                for (int k = 0; k < n_taps; k++)
                begin
                    w = extremes ? (((o + c + k) % 2 == 0) ? 16'h7fff : 16'h8000) : rand_value();
                    send_item(make_item(OP_WEIGHT, o, c, k, w, $urandom()));
                end
        for (int o = 0; o < n_out; o++)
            send_item(make_item(OP_BIAS, o, $urandom_range(0, 15), $urandom_range(0, 15),
                                16'($urandom()), $urandom()));
    endtask

    // one well-formed column, sometimes with junk transactions mixed in
    task automatic send_column(input bit noisy);
        int pick;
        for (int c = 0; c < n_in; c++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
            begin
                pick = $urandom_range(0, 1);
                if (pick == 0 || n_in == 16)
                    send_item(make_item(OP_RESERVED, $urandom_range(0, 15),
                                        $urandom_range(0, 15), $urandom_range(0, 15),
                                        16'($urandom()), $urandom()));
                else
                    send_item(make_item(OP_SAMPLE, $urandom_range(0, 15),
                                        $urandom_range(n_in, 15), $urandom_range(0, 15),
                                        16'($urandom()), $urandom()));
            end
            send_item(make_item(OP_SAMPLE, $urandom_range(0, 15), c, $urandom_range(0, 15),
                                rand_value(), $urandom()));
        end
    endtask

    // saturation, junk opcodes, ignored channels and out-of-order samples
    task automatic test_directed();
        logic [15:0] vals [4];
        vals = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
        configure(2, 2, 3, 2, 2, 1);
        load_coeffs(1'b1);
        send_item(make_item(OP_BIAS, 0, 0, 0, 16'h0, 32'h7fffffff));
        send_item(make_item(OP_BIAS, 1, 0, 0, 16'h0, 32'h80000000));
        send_item(make_item(OP_RESERVED, 15, 15, 15, 16'hffff, 32'hffffffff));
        send_item(make_item(OP_SAMPLE, 0, 5, 0, 16'h1234, 32'h0));
        for (int i = 0; i < 8; i++)
        begin
            send_item(make_item(OP_SAMPLE, 0, 0, 0, vals[i % 4], 32'h0));
            send_item(make_item(OP_SAMPLE, 0, 1, 0, vals[(i + 1) % 4], 32'h0));
        end
        // last channel first: the column closes holding the old slot value
        send_item(make_item(OP_SAMPLE, 0, 1, 0, 16'h7fff, 32'h0));
        send_item(make_item(OP_SAMPLE, 0, 0, 0, 16'h8000, 32'h0));
        send_item(make_item(OP_SAMPLE, 0, 1, 0, 16'h0001, 32'h0));
        // bias off with the same coefficients
        drain();
        write_reg(REG_BIAS_ENABLE, 5'd0);
        for (int i = 0; i < 4; i++)
            send_column(1'b0);
    endtask

    // widest column, out-of-range registers saturating
    task automatic test_input_extremes();
        configure(31, 0, 1, 7, 0, 1);
        load_coeffs(1'b0);
        for (int i = 0; i < 3; i++)
            send_column(1'b1);
    endtask

    // all sixteen output channels per position, with the receiver stalling
    task automatic test_output_extremes();
        configure(1, 16, 4, 1, 3, 1);
        load_coeffs(1'b0);
        for (int i = 0; i < 14; i++)
            send_column(1'b1);
    endtask

    // longest kernel at widest dilation and stride, no idling on either side
    task automatic test_long_kernel();
        configure(1, 1, 31, 4, 16, 0);
        load_coeffs(1'b0);
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        for (int i = 0; i < 80; i++)
            send_column(1'b0);
        in_gaps  = 1'b1;
        out_gaps = 1'b1;
    endtask

    // random small geometries with noise, and one full pause mid-stream
    task automatic test_random_mix();
        for (int p = 0; p < 2; p++)
        begin
            configure($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                      $urandom_range(0, 5), $urandom_range(1, 4), $urandom_range(0, 1));
            load_coeffs(1'b0);
            for (int i = 0; i < 8; i++)
            begin
                send_column(1'b1);
                if (p == 1 && i == 4)
                begin
                    in_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (conv_results_due.size() != 0);
                end
            end
        end
    endtask

    // result checking and receiver stall generation
    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (conv_results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", out_data);
            end
            else
            begin
                exp_r = conv_results_due.pop_front();
                if (out_data !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, actual %p", exp_r, out_data);
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (out_gaps && $urandom_range(0, 99) < 20)
        begin
            stall_left = gap_len();
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        for (int o = 0; o < 16; o++)
        begin
            biases[o] = '0;
            for (int c = 0; c < 16; c++)
                for (int k = 0; k < 16; k++)
                    coeffs[o][c][k] = '0;
        end
        for (int s = 0; s < HIST_COLS; s++)
            for (int c = 0; c < 16; c++)
                history[s][c] = '0;
        cols_done = 0;
        phase     = 0;
        pos_count = 0;
        ring_slot = 0;
        raw_regs  = '{5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd0};
        refresh_geometry();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_input_extremes();
        test_output_extremes();
        test_long_kernel();
        test_random_mix();

        drain();
        if (conv_results_due.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
